FILE: rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg: shared constants and types of the three-sensor gas scorer
// Widths, register indexes, spans, score weights and thresholds.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 8;
    localparam int FILT_W      = SAMPLE_BITS + FRAC_BITS;
    localparam int ALPHA_W     = 9;
    localparam int ACC_W       = FILT_W + ALPHA_W + 1;
    localparam int BASE_W      = 12;
    localparam int DIFF_W      = (SAMPLE_BITS > BASE_W) ? SAMPLE_BITS : BASE_W;
    localparam int SPAN_W      = 9;
    localparam int SCORE_W     = 7;
    localparam int TOTAL_W     = 11;
    localparam int RESULT_W    = 10;
    localparam int IN_DATA_W   = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [ALPHA_W-1:0] ONE_Q = ALPHA_W'(1 << FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_BASE_AMMONIA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SULFIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_METHANE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING    = 2'd3;

    localparam logic [BASE_W-1:0]  RST_BASE_AMMONIA = 12'd370;
    localparam logic [BASE_W-1:0]  RST_BASE_SULFIDE = 12'd1970;
    localparam logic [BASE_W-1:0]  RST_BASE_METHANE = 12'd190;
    localparam logic [ALPHA_W-1:0] RST_SMOOTHING    = 9'd77;

    localparam logic [SPAN_W-1:0] SPAN_AMMONIA = 9'd500;
    localparam logic [SPAN_W-1:0] SPAN_SULFIDE = 9'd400;
    localparam logic [SPAN_W-1:0] SPAN_METHANE = 9'd300;

    // score = delta*100/span: delta/5, delta/4, delta/3
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 12;
    localparam logic [RECIP_W-1:0] RECIP_FIVE  = 12'd820;
    localparam logic [RECIP_W-1:0] RECIP_THREE = 12'd1366;

    localparam logic [TOTAL_W-1:0] WEIGHT_AMMONIA = 11'd3;
    localparam logic [TOTAL_W-1:0] WEIGHT_SULFIDE = 11'd5;
    localparam logic [TOTAL_W-1:0] WEIGHT_METHANE = 11'd4;

    localparam logic [TOTAL_W-1:0] SCORE_CAP    = 11'd1000;
    localparam logic [TOTAL_W-1:0] DETECT_LIMIT = 11'd150;
    localparam logic [TOTAL_W-1:0] LEVEL_TWO    = 11'd200;
    localparam logic [TOTAL_W-1:0] LEVEL_THREE  = 11'd400;
    localparam logic [TOTAL_W-1:0] LEVEL_FOUR   = 11'd600;
    localparam logic [TOTAL_W-1:0] LEVEL_FIVE   = 11'd800;
    localparam logic [SCORE_W-1:0] METHANE_MIN  = 7'd30;

    localparam logic [2:0] INTENSITY_1 = 3'd1;
    localparam logic [2:0] INTENSITY_2 = 3'd2;
    localparam logic [2:0] INTENSITY_3 = 3'd3;
    localparam logic [2:0] INTENSITY_4 = 3'd4;
    localparam logic [2:0] INTENSITY_5 = 3'd5;

    typedef enum logic [1:0] {
        GAS_NONE    = 2'd0,
        GAS_SULFIDE = 2'd1,
        GAS_AMMONIA = 2'd2,
        GAS_METHANE = 2'd3
    } gas_t;

    typedef struct packed {
        gas_t                dominant_gas;
        logic [2:0]          intensity;
        logic                detected;
        logic [RESULT_W-1:0] score_tenths;
    } result_t;

endpackage

FILE: rtl/three_gas_sensor_scorer_top.sv
// ----------------------------------------------------------------------------
// three_gas_sensor_scorer_top: three-sensor gas scorer
// Takes one sample triple per request and returns one scored result per
// request, one request per cycle sustained while the output is not held by
// m_tready. The filter registers load at the edge that accepts a request,
// then the per-sensor score registers and then the output register, which
// presents the result on m_tvalid. The rate is set by the filter update,
// which closes its recurrence combinationally in each lane. The whole
// pipeline holds while a result waits on m_tready. Configuration writes are
// always taken and must be made while no request is in flight.
// ----------------------------------------------------------------------------
module three_gas_sensor_scorer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // [11:0] sample_ammonia, [23:12] sample_sulfide, [35:24] sample_methane
    input  logic [gss_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] score_tenths, [10] detected, [13:11] intensity, [15:14] dominant_gas
    output logic [gss_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gss_pkg::*;

    logic [BASE_W-1:0]  base_a_reg, base_s_reg, base_m_reg;
    logic [ALPHA_W-1:0] weight_reg;
    logic [ALPHA_W-1:0] alpha;
    logic               v1_reg, v2_reg, out_valid_reg;
    logic               adv;
    logic               accept;
    logic [SPAN_W-1:0]  delta_a, delta_s, delta_m;
    result_t            result;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_a_reg <= RST_BASE_AMMONIA;
            base_s_reg <= RST_BASE_SULFIDE;
            base_m_reg <= RST_BASE_METHANE;
            weight_reg <= RST_SMOOTHING;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASE_AMMONIA: base_a_reg <= cfg_data[BASE_W-1:0];
                REG_BASE_SULFIDE: base_s_reg <= cfg_data[BASE_W-1:0];
                REG_BASE_METHANE: base_m_reg <= cfg_data[BASE_W-1:0];
                REG_SMOOTHING:    weight_reg <= cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate alpha at one
    assign alpha = (weight_reg > ONE_Q) ? ONE_Q : weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    gss_lane u_lane_ammonia (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .sample   (s_tdata[0 +: SAMPLE_BITS]),
        .alpha    (alpha),
        .baseline (base_a_reg),
        .span     (SPAN_AMMONIA),
        .delta    (delta_a)
    );

    gss_lane u_lane_sulfide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .sample   (s_tdata[SAMPLE_BITS +: SAMPLE_BITS]),
        .alpha    (alpha),
        .baseline (base_s_reg),
        .span     (SPAN_SULFIDE),
        .delta    (delta_s)
    );

    gss_lane u_lane_methane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .sample   (s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
        .alpha    (alpha),
        .baseline (base_m_reg),
        .span     (SPAN_METHANE),
        .delta    (delta_m)
    );

    gss_merge u_merge (
        .aclk          (aclk),
        .adv           (adv),
        .delta_ammonia (delta_a),
        .delta_sulfide (delta_s),
        .delta_methane (delta_m),
        .result        (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(result);

endmodule

FILE: rtl/gss_lane.sv
// ----------------------------------------------------------------------------
// gss_lane: one sensor lane
// Exponential low-pass filter in fixed point, baseline removal and span clamp.
// ----------------------------------------------------------------------------
module gss_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  logic [gss_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [gss_pkg::ALPHA_W-1:0] alpha,
    input  logic [gss_pkg::BASE_W-1:0]  baseline,
    input  logic [gss_pkg::SPAN_W-1:0]  span,
    output logic [gss_pkg::SPAN_W-1:0]  delta
);
    import gss_pkg::*;

    logic [FILT_W-1:0]      filt_reg;
    logic [FILT_W-1:0]      filt_next;
    logic [ALPHA_W-1:0]     alpha_inv;
    logic [ACC_W-1:0]       acc;
    logic [SAMPLE_BITS-1:0] whole;
    logic [DIFF_W-1:0]      whole_x;
    logic [DIFF_W-1:0]      base_x;
    logic [DIFF_W-1:0]      diff;

    always_comb begin
        alpha_inv = ONE_Q - alpha;
        acc = ACC_W'(alpha) * ACC_W'({sample, {FRAC_BITS{1'b0}}})
            + ACC_W'(alpha_inv) * ACC_W'(filt_reg);
        filt_next = acc[FRAC_BITS +: FILT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (load) begin
            filt_reg <= filt_next;
        end
    end

    always_comb begin
        whole   = filt_reg[FILT_W-1:FRAC_BITS];
        whole_x = DIFF_W'(whole);
        base_x  = DIFF_W'(baseline);
        diff    = (whole_x > base_x) ? (whole_x - base_x) : '0;
        delta   = (diff > DIFF_W'(span)) ? span : diff[SPAN_W-1:0];
    end

endmodule

FILE: rtl/gss_merge.sv
// ----------------------------------------------------------------------------
// gss_merge: combine the three lanes
// Per-sensor scores, weighted total with saturation, level and dominant gas.
// ----------------------------------------------------------------------------
module gss_merge (
    input  logic                       aclk,
    input  logic                       adv,
    input  logic [gss_pkg::SPAN_W-1:0] delta_ammonia,
    input  logic [gss_pkg::SPAN_W-1:0] delta_sulfide,
    input  logic [gss_pkg::SPAN_W-1:0] delta_methane,
    output gss_pkg::result_t           result
);
    import gss_pkg::*;

    localparam int PROD_W = SPAN_W + RECIP_W;

    logic [PROD_W-1:0]  prod_a;
    logic [PROD_W-1:0]  prod_m;
    logic [SCORE_W-1:0] sa_next, ss_next, sm_next;
    logic [SCORE_W-1:0] sa_reg, ss_reg, sm_reg;
    logic [TOTAL_W-1:0] sum;
    logic [TOTAL_W-1:0] total;
    result_t            res_next;
    result_t            res_reg;

    always_comb begin
        prod_a  = PROD_W'(delta_ammonia) * PROD_W'(RECIP_FIVE);
        prod_m  = PROD_W'(delta_methane) * PROD_W'(RECIP_THREE);
        sa_next = prod_a[RECIP_SHIFT +: SCORE_W];
        ss_next = SCORE_W'(delta_sulfide >> 2);
        sm_next = prod_m[RECIP_SHIFT +: SCORE_W];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg  <= sa_next;
            ss_reg  <= ss_next;
            sm_reg  <= sm_next;
            res_reg <= res_next;
        end
    end

    always_comb begin
        sum = TOTAL_W'(sa_reg) * WEIGHT_AMMONIA
            + TOTAL_W'(ss_reg) * WEIGHT_SULFIDE
            + TOTAL_W'(sm_reg) * WEIGHT_METHANE;
        total = (sum > SCORE_CAP) ? SCORE_CAP : sum;

        res_next.score_tenths = total[RESULT_W-1:0];
        res_next.detected     = (total > DETECT_LIMIT);

        if (total < LEVEL_TWO) begin
            res_next.intensity = INTENSITY_1;
        end else if (total < LEVEL_THREE) begin
            res_next.intensity = INTENSITY_2;
        end else if (total < LEVEL_FOUR) begin
            res_next.intensity = INTENSITY_3;
        end else if (total < LEVEL_FIVE) begin
            res_next.intensity = INTENSITY_4;
        end else begin
            res_next.intensity = INTENSITY_5;
        end

        if (ss_reg > sa_reg && ss_reg > sm_reg) begin
            res_next.dominant_gas = GAS_SULFIDE;
        end else if (sa_reg > sm_reg) begin
            res_next.dominant_gas = GAS_AMMONIA;
        end else if (sm_reg > METHANE_MIN) begin
            res_next.dominant_gas = GAS_METHANE;
        end else begin
            res_next.dominant_gas = GAS_NONE;
        end
    end

    assign result = res_reg;

endmodule

FILE: verif/three_gas_sensor_scorer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_gas_sensor_scorer_top_test: self-checking bench of the gas scorer
// Streams sample triples through the scorer under several register settings
// and idle patterns. A local model of the three low-pass filters and the
// scoring rules predicts every result, and each accepted result is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module three_gas_sensor_scorer_top_test;

    import gss_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SEGMENTS     = 8;
    localparam int SEGMENT_REQS = 106;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // model copy of registers and filters
    logic [BASE_W-1:0]      base_ammonia;
    logic [BASE_W-1:0]      base_sulfide;
    logic [BASE_W-1:0]      base_methane;
    logic [ALPHA_W-1:0]     alpha_weight;
    logic [FILT_W-1:0]      filt_ammonia;
    logic [FILT_W-1:0]      filt_sulfide;
    logic [FILT_W-1:0]      filt_methane;

    result_t                pending_scores[$];
    int                     fault_count;
    int                     quiet_cycles;
    int                     sender_idle_pct;
    int                     sink_stall_pct;

    three_gas_sensor_scorer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    function automatic logic [FILT_W-1:0] smooth(logic [FILT_W-1:0] f,
                                                 logic [SAMPLE_BITS-1:0] x,
                                                 logic [ALPHA_W-1:0] weight);
        longint unsigned a;
        longint unsigned fw;
        longint unsigned xw;
        longint unsigned acc;
        a   = (weight > 9'd256) ? 256 : weight;
        fw  = f;
        xw  = x;
        acc = a * (xw << FRAC_BITS) + (256 - a) * fw;
        return FILT_W'(acc >> FRAC_BITS);
    endfunction

    function automatic int unsigned gas_score(logic [FILT_W-1:0] f,
                                              logic [BASE_W-1:0] base,
                                              int unsigned span);
        int unsigned whole;
        int unsigned delta;
        whole = f >> FRAC_BITS;
        delta = (whole > base) ? whole - base : 0;
        if (delta > span) begin
            delta = span;
        end
        return (delta * 100) / span;
    endfunction

    task automatic score_reading(input logic [SAMPLE_BITS-1:0] xa, xs, xm);
        int unsigned sa;
        int unsigned ss;
        int unsigned sm;
        int unsigned total;
        result_t     r;
        filt_ammonia = smooth(filt_ammonia, xa, alpha_weight);
        filt_sulfide = smooth(filt_sulfide, xs, alpha_weight);
        filt_methane = smooth(filt_methane, xm, alpha_weight);
        sa = gas_score(filt_ammonia, base_ammonia, 500);
        ss = gas_score(filt_sulfide, base_sulfide, 400);
        sm = gas_score(filt_methane, base_methane, 300);
        total = 3 * sa + 5 * ss + 4 * sm;
        if (total > 1000) begin
            total = 1000;
        end
        r.score_tenths = RESULT_W'(total);
        r.detected     = (total > 150);
        if (total < 200) begin
            r.intensity = INTENSITY_1;
        end else if (total < 400) begin
            r.intensity = INTENSITY_2;
        end else if (total < 600) begin
            r.intensity = INTENSITY_3;
        end else if (total < 800) begin
            r.intensity = INTENSITY_4;
        end else begin
            r.intensity = INTENSITY_5;
        end
        if (ss > sa && ss > sm) begin
            r.dominant_gas = GAS_SULFIDE;
        end else if (sa > sm) begin
            r.dominant_gas = GAS_AMMONIA;
        end else if (sm > 30) begin
            r.dominant_gas = GAS_METHANE;
        end else begin
            r.dominant_gas = GAS_NONE;
        end
        pending_scores.push_back(r);
    endtask

    task automatic send_reading(input logic [SAMPLE_BITS-1:0] xa, xs, xm);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = IN_DATA_W'({xm, xs, xa});
        s_tvalid = 1'b1;
        taken    = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            if (s_tready) begin
                taken = 1'b1;
                score_reading(xa, xs, xm);
            end
            @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_scores.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        bit taken;
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        taken     = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            if (cfg_ready) begin
                taken = 1'b1;
                case (idx)
                    REG_BASE_AMMONIA: base_ammonia = value;
                    REG_BASE_SULFIDE: base_sulfide = value;
                    REG_BASE_METHANE: base_methane = value;
                    REG_SMOOTHING:    alpha_weight = value[ALPHA_W-1:0];
                    default: ;
                endcase
            end
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [BASE_W-1:0] base,
                                                           int span);
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(4095));
            3: v = $urandom_range(1) ? 4095 : 0;
            default: v = int'(base) + int'($urandom_range(span + 60)) - 30;
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 4095) begin
            v = 4095;
        end
        return SAMPLE_BITS'(v);
    endfunction

    // results
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (pending_scores.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
                fault_count++;
            end else begin
                want = pending_scores.pop_front();
                if (got.score_tenths !== want.score_tenths) begin
                    $display("%0t score_tenths expected %0d actual %0d",
                             $time, want.score_tenths, got.score_tenths);
                    fault_count++;
                end
                if (got.detected !== want.detected) begin
                    $display("%0t detected expected %0b actual %0b",
                             $time, want.detected, got.detected);
                    fault_count++;
                end
                if (got.intensity !== want.intensity) begin
                    $display("%0t intensity expected %0d actual %0d",
                             $time, want.intensity, got.intensity);
                    fault_count++;
                end
                if (got.dominant_gas !== want.dominant_gas) begin
                    $display("%0t dominant_gas expected %0d actual %0d",
                             $time, want.dominant_gas, got.dominant_gas);
                    fault_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_reset_defaults();
        send_reading(12'hFFF, 12'hFFF, 12'hFFF);
        send_reading(12'hFFF, 12'hFFF, 12'hFFF);
        send_reading(12'h000, 12'h000, 12'h000);
    endtask

    task automatic test_field_extremes();
        wait_drained();
        write_register(REG_SMOOTHING, 12'd256);
        write_register(REG_BASE_AMMONIA, 12'd0);
        write_register(REG_BASE_SULFIDE, 12'd0);
        write_register(REG_BASE_METHANE, 12'd0);
        send_reading(12'd0, 12'd0, 12'd0);
        send_reading(12'hFFF, 12'hFFF, 12'hFFF);
        send_reading(12'd0, 12'd200, 12'd0);
        send_reading(12'd250, 12'd0, 12'd0);
        send_reading(12'd0, 12'd0, 12'd20);
        send_reading(12'd0, 12'd0, 12'd100);
        send_reading(12'd0, 12'd120, 12'd0);
        send_reading(12'd10, 12'd116, 12'd0);
        send_reading(12'd0, 12'd160, 12'd0);
        send_reading(12'd15, 12'd152, 12'd0);
        send_reading(12'hFFF, 12'd0, 12'hFFF);
    endtask

    task automatic test_smoothing_limits();
        wait_drained();
        write_register(REG_SMOOTHING, 12'hFFF);
        send_reading(12'd300, 12'd200, 12'd150);
        wait_drained();
        write_register(REG_SMOOTHING, 12'd0);
        send_reading(12'hFFF, 12'd0, 12'hFFF);
        send_reading(12'd0, 12'hFFF, 12'd0);
        wait_drained();
        write_register(REG_SMOOTHING, 12'd1);
        send_reading(12'hFFF, 12'hFFF, 12'hFFF);
        send_reading(12'hFFF, 12'hFFF, 12'hFFF);
    endtask

    task automatic test_baseline_above();
        wait_drained();
        write_register(REG_SMOOTHING, 12'd256);
        write_register(REG_BASE_AMMONIA, 12'hFFF);
        write_register(REG_BASE_SULFIDE, 12'hFFF);
        write_register(REG_BASE_METHANE, 12'hFFF);
        send_reading(12'hFFF, 12'hFFF, 12'hFFF);
        send_reading(12'd100, 12'd200, 12'd300);
    endtask

    task automatic test_random_traffic();
        int seg;
        int n;
        logic [CFG_DATA_W-1:0] w;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            case (seg % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin sender_idle_pct = 21; sink_stall_pct = 21; end
            endcase
            write_register(REG_BASE_AMMONIA,
                           CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(4095)
                                                                : $urandom_range(2000)));
            write_register(REG_BASE_SULFIDE,
                           CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(4095)
                                                                : $urandom_range(2000)));
            write_register(REG_BASE_METHANE,
                           CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(4095)
                                                                : $urandom_range(2000)));
            case ($urandom_range(7))
                0: w = CFG_DATA_W'($urandom_range(4095));
                1: w = $urandom_range(1) ? 12'd1 : 12'd256;
                default: w = CFG_DATA_W'($urandom_range(256, 1));
            endcase
            write_register(REG_SMOOTHING, w);
            for (n = 0; n < SEGMENT_REQS; n++) begin
                send_reading(pick_sample(base_ammonia, 500),
                             pick_sample(base_sulfide, 400),
                             pick_sample(base_methane, 300));
                if (n == SEGMENT_REQS / 2 && seg == 3) begin
                    wait_drained();
                end
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_tdata         = '0;
        s_tvalid        = 1'b0;
        m_tready        = 1'b1;
        cfg_valid       = 1'b0;
        cfg_index       = REG_BASE_AMMONIA;
        cfg_data        = '0;
        fault_count     = 0;
        quiet_cycles    = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        base_ammonia    = RST_BASE_AMMONIA;
        base_sulfide    = RST_BASE_SULFIDE;
        base_methane    = RST_BASE_METHANE;
        alpha_weight    = RST_SMOOTHING;
        filt_ammonia    = '0;
        filt_sulfide    = '0;
        filt_methane    = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_smoothing_limits();
        test_baseline_above();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/gss_pkg.sv
rtl/gss_lane.sv
rtl/gss_merge.sv
rtl/three_gas_sensor_scorer_top.sv
verif/three_gas_sensor_scorer_top_test.sv
